[hw/rtl/tcds_pkg.sv]
package tcds_pkg;

  // Defaults and fixed limits
  localparam int         WAIT_SLOTS_DEF = 8;
  localparam logic [7:0] TPS_RESET      = 8'd30;
  localparam logic [5:0] SEC_LIMIT      = 6'd60;
  localparam logic [5:0] MIN_LIMIT      = 6'd60;
  localparam logic [4:0] HOUR_LIMIT     = 5'd24;

  // Command codes
  localparam logic [2:0] CMD_DELAY     = 3'd0;
  localparam logic [2:0] CMD_TICK      = 3'd1;
  localparam logic [2:0] CMD_READ_UP   = 3'd2;
  localparam logic [2:0] CMD_READ_WALL = 3'd3;
  localparam logic [2:0] CMD_SET_WALL  = 3'd4;

  // Reply kinds
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_UPTIME  = 3'd1;
  localparam logic [2:0] KIND_WALL    = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_REFUSED = 3'd4;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } clk_time_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  client;
    logic [15:0] delay_ticks;
    clk_time_t   set_time;
  } in_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       push_slot;
    logic       do_tick;
    logic       set_wall;
    logic       rd_slot;
    logic       step;
    logic       out_load;
    logic [2:0] out_kind;
    logic       out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] command;
    logic       dly_zero;
    logic       full;
    logic       used_zero;
    logic       left_zero;
    logic       scan_last;
    logic       out_free;
  } dp_status_t;

  // Advance a clock by one second, wrapping any field at or above its limit
  function automatic clk_time_t advance_time(input clk_time_t t);
    clk_time_t  r;
    logic [5:0] s;
    logic [5:0] m;
    logic [4:0] h;
    r = t;
    s = t.seconds + 6'd1;
    m = t.minutes + 6'd1;
    h = t.hours + 5'd1;
    if (s < SEC_LIMIT) begin
      r.seconds = s;
    end else begin
      r.seconds = '0;
      if (m < MIN_LIMIT) begin
        r.minutes = m;
      end else begin
        r.minutes = '0;
        r.hours   = (h < HOUR_LIMIT) ? h : 5'd0;
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/tcds_ctrl.sv]
module tcds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcds_pkg::dp_status_t sts,
  output tcds_pkg::dp_cmd_t    cmd
);
  import tcds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_FINAL  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] fin_kind_r, fin_kind_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Kind of the closing result, held until it is pushed out
  always_ff @(posedge clk) begin
    fin_kind_r <= fin_kind_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    fin_kind_nxt = fin_kind_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt    = ST_FINAL;
        fin_kind_nxt = KIND_ACK;
        case (sts.command)
          CMD_DELAY: begin
            if (sts.dly_zero) begin
              fin_kind_nxt = KIND_ACK;
            end else if (sts.full) begin
              fin_kind_nxt = KIND_REFUSED;
            end else begin
              cmd.push_slot = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          CMD_TICK: begin
            cmd.do_tick = 1'b1;
            if (!sts.used_zero) begin
              cmd.rd_slot = 1'b1;
              state_nxt   = ST_CHECK;
            end
          end
          CMD_READ_UP:   fin_kind_nxt = KIND_UPTIME;
          CMD_READ_WALL: fin_kind_nxt = KIND_WALL;
          CMD_SET_WALL:  cmd.set_wall = 1'b1;
          default:       fin_kind_nxt = KIND_ACK;
        endcase
      end
      ST_CHECK: begin
        // Release an expired slot only when the output register can take it
        if (!sts.left_zero || sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.left_zero) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_RELEASE;
          end
          if (sts.scan_last) begin
            state_nxt = ST_FINAL;
          end else begin
            cmd.rd_slot = 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = fin_kind_r;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/tcds_dp.sv]
module tcds_dp #(
  parameter int WAIT_SLOTS = tcds_pkg::WAIT_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  tcds_pkg::in_item_t   in_item,
  input  tcds_pkg::dp_cmd_t    cmd,
  output tcds_pkg::dp_status_t sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_kind,
  output logic [7:0]           out_client,
  output tcds_pkg::clk_time_t  out_time,
  output logic                 out_last
);
  import tcds_pkg::*;

  localparam int IDX_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int CNT_W = $clog2(WAIT_SLOTS + 1);

  typedef struct packed {
    logic [7:0]  client;
    logic [15:0] remaining;
  } slot_t;

  // Configuration and clock state
  logic [7:0]  tps_r;
  logic [7:0]  tick_cnt_r, tick_cnt_nxt;
  clk_time_t   up_r, wall_r;
  in_item_t    in_r;

  // Wait slot bookkeeping
  slot_t             slot_mem [WAIT_SLOTS];
  slot_t             rd_entry_r;
  logic [CNT_W-1:0]  used_r, keep_r, scan_r;
  logic [CNT_W-1:0]  scan_inc, keep_inc;
  logic [15:0]       left;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, rd_addr;
  slot_t             mem_wdata;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [7:0]  out_client_r;
  clk_time_t   out_time_r;
  logic        out_last_r;
  logic        out_free;

  assign tick_cnt_nxt = tick_cnt_r + 8'd1;
  assign left         = rd_entry_r.remaining - 16'd1;
  assign scan_inc     = scan_r + CNT_W'(1);
  assign keep_inc     = keep_r + CNT_W'(1);
  assign out_free     = !out_valid_r || out_ready;

  // Status toward the controller
  assign sts.command   = in_r.command;
  assign sts.dly_zero  = (in_r.delay_ticks == 16'd0);
  assign sts.full      = (used_r == CNT_W'(WAIT_SLOTS));
  assign sts.used_zero = (used_r == '0);
  assign sts.left_zero = (left == 16'd0);
  assign sts.scan_last = (scan_inc == used_r);
  assign sts.out_free  = out_free;

  // Latch the accepted transfer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_item;
    end
  end

  // Ticks-per-second register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_wr_en) begin
      tps_r <= cfg_wr_data;
    end
  end

  // Prescaler, uptime and wall clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= '0;
      up_r       <= '0;
      wall_r     <= '0;
    end else if (cmd.do_tick) begin
      if (tick_cnt_nxt == tps_r) begin
        tick_cnt_r <= '0;
        up_r       <= advance_time(up_r);
        wall_r     <= advance_time(wall_r);
      end else begin
        tick_cnt_r <= tick_cnt_nxt;
      end
    end else if (cmd.set_wall) begin
      wall_r <= in_r.set_time;
    end
  end

  // Slot memory: one write port, one registered read port
  assign mem_we    = cmd.push_slot || (cmd.step && !sts.left_zero);
  assign mem_waddr = cmd.push_slot ? used_r[IDX_W-1:0] : keep_r[IDX_W-1:0];
  assign mem_wdata = cmd.push_slot ? slot_t'{in_r.client, in_r.delay_ticks}
                                   : slot_t'{rd_entry_r.client, left};
  assign rd_addr   = cmd.step ? scan_inc[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_slot) begin
      rd_entry_r <= slot_mem[rd_addr];
    end
  end

  // Slot count, scan and compaction pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      keep_r <= '0;
      scan_r <= '0;
    end else if (cmd.push_slot) begin
      used_r <= used_r + CNT_W'(1);
    end else if (cmd.do_tick) begin
      keep_r <= '0;
      scan_r <= '0;
    end else if (cmd.step) begin
      scan_r <= scan_inc;
      if (!sts.left_zero) begin
        keep_r <= keep_inc;
      end
      if (sts.scan_last) begin
        used_r <= sts.left_zero ? keep_r : keep_inc;
      end
    end
  end

  // Output register: load a result, drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r   <= cmd.out_kind;
      out_last_r   <= cmd.out_last;
      out_client_r <= (cmd.out_kind == KIND_RELEASE) ? rd_entry_r.client : in_r.client;
      case (cmd.out_kind)
        KIND_UPTIME: out_time_r <= up_r;
        KIND_WALL:   out_time_r <= wall_r;
        default:     out_time_r <= '0;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_client = out_client_r;
  assign out_time   = out_time_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(WAIT_SLOTS))
    else $error("slot count above capacity");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result loaded over an untransferred result");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_slot |=> used_r == $past(used_r) + CNT_W'(1) && $past(!sts.full))
    else $error("slot pushed while full");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> scan_r < used_r)
    else $error("scan beyond slots in use");
`endif

endmodule

[hw/rtl/tick_clock_and_delay_server_top.sv]
// Tick clock and delay server.
// Input channel (in_*): one command per transfer; in_tuser carries the command
// code (delay, tick, read uptime, read wall time, set wall time), in_tdata the
// client, delay length and new wall time. Result channel (out_*): out_tuser is
// the reply kind, out_tdata the client and reported time, out_tlast marks the
// final result of a command. cfg_wr_en/cfg_wr_data write ticks per second.
// A read, set, zero or refused delay gives its single result through the
// decode and final states and the output register; a stored delay gives none.
// For a tick the slot memory has one read port and is walked one slot per
// cycle unless a release waits for the output register, releases first,
// then the ack. The next command is accepted when the current one is finished.
// Reset clears the clocks, the prescaler and all slots and sets ticks per
// second to 30. When the receiver stalls, the finished result waits in the
// output register; the block keeps accepting and processing until it needs
// to emit another result, and then holds until the register is taken.
module tick_clock_and_delay_server_top #(
  parameter int WAIT_SLOTS = tcds_pkg::WAIT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // client, delay_ticks, set_hours, set_minutes, set_seconds
  input  logic [2:0]  in_tuser,   // command
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // reply_client, out_hours, out_minutes, out_seconds
  output logic [2:0]  out_tuser,  // reply_kind
  output logic        out_tlast
);
  import tcds_pkg::*;

  in_item_t   in_item;
  dp_cmd_t    cmd;
  dp_status_t sts;
  logic [7:0] out_client;
  clk_time_t  out_time;

  // Unpack the input transfer
  assign in_item.command          = in_tuser;
  assign in_item.client           = in_tdata[7:0];
  assign in_item.delay_ticks      = in_tdata[23:8];
  assign in_item.set_time.hours   = in_tdata[28:24];
  assign in_item.set_time.minutes = in_tdata[34:29];
  assign in_item.set_time.seconds = in_tdata[40:35];

  tcds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcds_dp #(
    .WAIT_SLOTS (WAIT_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (out_tuser),
    .out_client  (out_client),
    .out_time    (out_time),
    .out_last    (out_tlast)
  );

  // Pack the result transfer
  assign out_tdata = {7'd0, out_time.seconds, out_time.minutes, out_time.hours, out_client};

endmodule

[tb/tick_clock_and_delay_server_top_test.sv]
`timescale 1ns / 1ps

module tick_clock_and_delay_server_top_test;
  import tcds_pkg::*;

  // Spare command codes: the block acknowledges them and changes nothing
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int         SLOTS      = WAIT_SLOTS_DEF;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] who;
    clk_time_t  stamp;
    logic       fin;
  } reply_t;

  // One directed command, with its single reply typed in where it is obvious
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  who;
    logic [15:0] dly;
    logic [4:0]  sh;
    logic [5:0]  sm;
    logic [5:0]  ss;
    logic        typed;
    logic [2:0]  kind;
    logic [4:0]  eh;
    logic [5:0]  em;
    logic [5:0]  es;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = 48'd0;   // client, delay_ticks, set_hours, set_minutes, set_seconds
  logic [2:0]  in_tuser = 3'd0;    // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // reply_client, out_hours, out_minutes, out_seconds
  logic [2:0]  out_tuser;          // reply_kind
  logic        out_tlast;

  // Mirror of the block's state
  logic [7:0]  rate;
  logic [7:0]  tick_cnt;
  clk_time_t   up_t;
  clk_time_t   wall_t;
  logic [7:0]  slot_who [SLOTS];
  logic [15:0] slot_left [SLOTS];
  int          slots_used;

  reply_t      pending_replies[$];
  reply_t      fresh_replies[$];
  int          err_count = 0;
  int          send_idle = 0;
  int          rcv_idle = 0;

  script_row_t script [25] = '{
    '{CMD_READ_UP,   8'h00, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b1, KIND_UPTIME, 5'd0,  6'd0,  6'd0},
    '{CMD_READ_WALL, 8'hFF, 16'hFFFF, 5'd31, 6'd63, 6'd63, 1'b1, KIND_WALL,   5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h5A, 16'h0000, 5'd31, 6'd63, 6'd63, 1'b1, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_SET_WALL,  8'hA5, 16'h0000, 5'd23, 6'd59, 6'd59, 1'b1, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_READ_WALL, 8'h3C, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b1, KIND_WALL,   5'd23, 6'd59, 6'd59},
    '{CMD_SET_WALL,  8'h11, 16'h0000, 5'd31, 6'd63, 6'd63, 1'b1, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_READ_WALL, 8'h22, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b1, KIND_WALL,   5'd31, 6'd63, 6'd63},
    '{CMD_SPARE5,    8'h33, 16'h1234, 5'd1,  6'd2,  6'd3,  1'b1, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_SPARE6,    8'h44, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b1, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_SPARE7,    8'h55, 16'hFFFF, 5'd31, 6'd63, 6'd63, 1'b1, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_SET_WALL,  8'h66, 16'h0000, 5'd23, 6'd59, 6'd59, 1'b1, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h80, 16'd1,    5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h81, 16'd2,    5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h82, 16'd3,    5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h83, 16'd1,    5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h84, 16'd4,    5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h85, 16'd2,    5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h86, 16'd3,    5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h87, 16'd2,    5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_DELAY,     8'h90, 16'hFFFF, 5'd0,  6'd0,  6'd0,  1'b1, KIND_REFUSED, 5'd0, 6'd0,  6'd0},
    '{CMD_TICK,      8'h01, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_TICK,      8'h02, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_READ_UP,   8'h03, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b1, KIND_UPTIME, 5'd0,  6'd0,  6'd0},
    '{CMD_TICK,      8'h04, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0},
    '{CMD_TICK,      8'hFF, 16'h0000, 5'd0,  6'd0,  6'd0,  1'b0, KIND_ACK,    5'd0,  6'd0,  6'd0}
  };

  tick_clock_and_delay_server_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_error(input string msg);
    $display("%0t: %s", $time, msg);
    err_count++;
  endtask

  // Advance a clock by one second; fields at or past their limit clear and carry
  function automatic clk_time_t next_second(input clk_time_t t);
    clk_time_t r;
    r = t;
    r.seconds = t.seconds + 6'd1;
    if (r.seconds >= SEC_LIMIT) begin
      r.seconds = 6'd0;
      r.minutes = t.minutes + 6'd1;
      if (r.minutes >= MIN_LIMIT) begin
        r.minutes = 6'd0;
        r.hours = t.hours + 5'd1;
        if (r.hours >= HOUR_LIMIT) begin
          r.hours = 5'd0;
        end
      end
    end
    return r;
  endfunction

  // Serve one command against the mirrored state; replies land in fresh_replies
  task automatic serve_command(input in_item_t c);
    int         keep;
    logic [15:0] left;
    fresh_replies.delete();
    case (c.command)
      CMD_DELAY: begin
        if (c.delay_ticks == 16'd0) begin
          fresh_replies.push_back('{KIND_ACK, c.client, '0, 1'b1});
        end else if (slots_used >= SLOTS) begin
          fresh_replies.push_back('{KIND_REFUSED, c.client, '0, 1'b1});
        end else begin
          slot_who[slots_used] = c.client;
          slot_left[slots_used] = c.delay_ticks;
          slots_used++;
        end
      end
      CMD_TICK: begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt == rate) begin
          tick_cnt = 8'd0;
          up_t = next_second(up_t);
          wall_t = next_second(wall_t);
        end
        // count down every slot, release the expired ones in arrival order
        keep = 0;
        for (int i = 0; i < slots_used; i++) begin
          left = slot_left[i] - 16'd1;
          if (left == 16'd0) begin
            fresh_replies.push_back('{KIND_RELEASE, slot_who[i], '0, 1'b0});
          end else begin
            slot_who[keep] = slot_who[i];
            slot_left[keep] = left;
            keep++;
          end
        end
        slots_used = keep;
        fresh_replies.push_back('{KIND_ACK, c.client, '0, 1'b1});
      end
      CMD_READ_UP: begin
        fresh_replies.push_back('{KIND_UPTIME, c.client, up_t, 1'b1});
      end
      CMD_READ_WALL: begin
        fresh_replies.push_back('{KIND_WALL, c.client, wall_t, 1'b1});
      end
      CMD_SET_WALL: begin
        wall_t = c.set_time;
        fresh_replies.push_back('{KIND_ACK, c.client, '0, 1'b1});
      end
      default: begin
        fresh_replies.push_back('{KIND_ACK, c.client, '0, 1'b1});
      end
    endcase
  endtask

  // Offer one command, hold it until the transfer, then record what it must cause
  task automatic send_cmd(input in_item_t c, input logic typed, input reply_t want);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.command;
    in_tdata <= {7'd0, c.set_time.seconds, c.set_time.minutes, c.set_time.hours,
                 c.delay_ticks, c.client};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    serve_command(c);
    if (typed) begin
      pending_replies.push_back(want);
    end else begin
      foreach (fresh_replies[i]) begin
        pending_replies.push_back(fresh_replies[i]);
      end
    end
  endtask

  // Drop valid and hold until every reply is in and the block has gone quiet
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_rate(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    rate = v;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly delays and ticks so slots fill, expire and get refused
  function automatic in_item_t random_cmd();
    in_item_t c;
    int       pick;
    c.client = 8'($urandom);
    c.delay_ticks = 16'($urandom);
    c.set_time.hours = 5'($urandom);
    c.set_time.minutes = 6'($urandom);
    c.set_time.seconds = 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) begin
      c.command = CMD_DELAY;
      if ($urandom_range(9) == 0) begin
        c.delay_ticks = 16'd0;
      end else if (slots_used < SLOTS) begin
        // a long wait would pin a slot for the rest of the run
        c.delay_ticks = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 1))
                                                 : 16'($urandom_range(8, 1));
      end
    end else if (pick < 70) begin
      c.command = CMD_TICK;
    end else if (pick < 78) begin
      c.command = CMD_READ_UP;
    end else if (pick < 86) begin
      c.command = CMD_READ_WALL;
    end else if (pick < 94) begin
      c.command = CMD_SET_WALL;
      if ($urandom_range(6) != 0) begin
        c.set_time.hours = 5'($urandom_range(23));
        c.set_time.minutes = 6'($urandom_range(59));
        c.set_time.seconds = 6'($urandom_range(59));
      end
    end else begin
      c.command = 3'($urandom_range(CMD_SPARE7, CMD_SPARE5));
    end
    return c;
  endfunction

  task automatic run_phase(input logic [7:0] new_rate, input int n,
                           input int s_idle, input int r_idle);
    in_item_t c;
    send_idle = s_idle;
    rcv_idle = r_idle;
    // line the prescaler up so the next tick ends a second and clears it
    quiesce();
    write_rate(tick_cnt + 8'd1);
    c = random_cmd();
    c.command = CMD_TICK;
    send_cmd(c, 1'b0, '0);
    quiesce();
    write_rate(new_rate);
    repeat (n) begin
      c = random_cmd();
      send_cmd(c, 1'b0, '0);
      if ($urandom_range(24) == 0) begin
        quiesce();
      end
    end
  endtask

  // Receiver side: stall at the current rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // Check every reply transfer against the oldest expectation
  always @(posedge clk) begin : watch_replies
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        note_error($sformatf("unexpected reply kind %0d client %0d", out_tuser, out_tdata[7:0]));
      end else begin
        want = pending_replies.pop_front();
        if (out_tuser !== want.kind) begin
          note_error($sformatf("kind got %0d want %0d", out_tuser, want.kind));
        end
        if (out_tdata[7:0] !== want.who) begin
          note_error($sformatf("client got %0d want %0d", out_tdata[7:0], want.who));
        end
        if (out_tdata[12:8] !== want.stamp.hours) begin
          note_error($sformatf("hours got %0d want %0d", out_tdata[12:8], want.stamp.hours));
        end
        if (out_tdata[18:13] !== want.stamp.minutes) begin
          note_error($sformatf("minutes got %0d want %0d", out_tdata[18:13],
                               want.stamp.minutes));
        end
        if (out_tdata[24:19] !== want.stamp.seconds) begin
          note_error($sformatf("seconds got %0d want %0d", out_tdata[24:19],
                               want.stamp.seconds));
        end
        if (out_tlast !== want.fin) begin
          note_error($sformatf("last got %0d want %0d", out_tlast, want.fin));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    in_item_t c;
    reply_t   want;
    rate = TPS_RESET;
    tick_cnt = 8'd0;
    up_t = '0;
    wall_t = '0;
    slots_used = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed commands at the reset rate, no idling
    foreach (script[i]) begin
      c.command = script[i].cmd;
      c.client = script[i].who;
      c.delay_ticks = script[i].dly;
      c.set_time = '{script[i].sh, script[i].sm, script[i].ss};
      want = '{script[i].kind, script[i].who, '{script[i].eh, script[i].em, script[i].es}, 1'b1};
      send_cmd(c, script[i].typed, want);
    end

    run_phase(8'd1, 30, 37, 88);
    run_phase(8'd255, 30, 88, 37);
    run_phase(8'd0, 30, 0, 0);
    run_phase(8'd7, 30, 0, 0);

    quiesce();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
